[rtl/ptu_pkg.sv]
// Shared widths, codes and types of the planar trilateration unit.
`default_nettype none
package ptu_pkg;
  // Range width in bits, two's complement.
  localparam int DIST_BITS = 16;
  // Magnitude bits of a non-negative range and of its square.
  localparam int MAG_W = DIST_BITS - 1;
  localparam int SQ_W = 2 * MAG_W;
  // Signed width of the two numerators N2 and N3.
  localparam int N_W = ((SQ_W > 32) ? SQ_W : 32) + 2;
  // Signed width of the y numerator N3*d - i*N2.
  localparam int NUM_W = N_W + 17;
  // Quotient magnitude width; also the number of divider stages.
  localparam int Q_W = NUM_W - 1;

  // Configuration register widths.
  localparam int BASE_W = 15;
  localparam int TX_W = 16;
  localparam int TY_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Divisor widths: 2*d and 2*d*j.
  localparam int DX_W = BASE_W + 1;
  localparam int DY_W = BASE_W + TY_W + 1;

  localparam int POS_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_Y = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK = 2'd0,
    STAT_NEG = 2'd1,
    STAT_UNCAL = 2'd2
  } status_t;

  // One item in flight through the divider: dividends become quotients.
  typedef struct packed {
    logic valid;
    status_t status;
    logic neg_x;
    logic neg_y;
    logic [Q_W-1:0] q_x;
    logic [Q_W-1:0] q_y;
  } div_lane_t;
endpackage
`default_nettype wire

[rtl/ptu_if.sv]
// Channel interfaces of the planar trilateration unit.
`default_nettype none
interface ptu_in_if;
  import ptu_pkg::*;
  logic valid;
  logic ready;
  logic signed [DIST_BITS-1:0] range_a;
  logic signed [DIST_BITS-1:0] range_b;
  logic signed [DIST_BITS-1:0] range_c;
  modport source (output valid, output range_a, output range_b, output range_c,
                  input ready);
  modport sink (input valid, input range_a, input range_b, input range_c,
                output ready);
  modport monitor (input valid, input ready, input range_a, input range_b,
                   input range_c);
endinterface

interface ptu_out_if;
  import ptu_pkg::*;
  logic valid;
  logic ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [1:0] status;
  modport source (output valid, output pos_x, output pos_y, output status,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input status,
                output ready);
  modport monitor (input valid, input ready, input pos_x, input pos_y,
                   input status);
endinterface

interface ptu_cfg_if;
  import ptu_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/ptu_div.sv]
// Pipelined restoring divider, one quotient bit per stage, x and y lanes.
`default_nettype none
module ptu_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [ptu_pkg::DX_W-1:0] div_x,
  input  logic [ptu_pkg::DY_W-1:0] div_y,
  input  ptu_pkg::div_lane_t din,
  output ptu_pkg::div_lane_t dout
);
  import ptu_pkg::*;

  // Stage inputs; entry k feeds stage k, entry Q_W is the result.
  div_lane_t lane_w [Q_W+1];
  logic [DX_W-1:0] rem_x_w [Q_W];
  logic [DY_W-1:0] rem_y_w [Q_W];

  assign lane_w[0] = din;
  assign rem_x_w[0] = '0;
  assign rem_y_w[0] = '0;
  assign dout = lane_w[Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DX_W:0] tx;
    logic [DY_W:0] ty;
    logic ge_x;
    logic ge_y;
    logic [DX_W-1:0] rx_nxt;
    logic [DY_W-1:0] ry_nxt;
    div_lane_t lane_nxt;
    div_lane_t lane_r;

    // Shift in the next dividend bit and try one subtraction per lane.
    always_comb begin
      tx = {rem_x_w[k], lane_w[k].q_x[Q_W-1]};
      ty = {rem_y_w[k], lane_w[k].q_y[Q_W-1]};
      ge_x = (tx >= {1'b0, div_x});
      ge_y = (ty >= {1'b0, div_y});
      rx_nxt = ge_x ? DX_W'(tx - {1'b0, div_x}) : DX_W'(tx);
      ry_nxt = ge_y ? DY_W'(ty - {1'b0, div_y}) : DY_W'(ty);
      lane_nxt = lane_w[k];
      lane_nxt.q_x = {lane_w[k].q_x[Q_W-2:0], ge_x};
      lane_nxt.q_y = {lane_w[k].q_y[Q_W-2:0], ge_y};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lane_r.valid <= 1'b0;
      end else if (adv) begin
        lane_r <= lane_nxt;
      end
    end
    assign lane_w[k+1] = lane_r;

    // The last stage keeps no remainder.
    if (k < Q_W - 1) begin : g_rem
      logic [DX_W-1:0] rx_r;
      logic [DY_W-1:0] ry_r;
      always_ff @(posedge clk) begin
        if (adv) begin
          rx_r <= rx_nxt;
          ry_r <= ry_nxt;
        end
      end
      assign rem_x_w[k+1] = rx_r;
      assign rem_y_w[k+1] = ry_r;
    end
  end
endmodule
`default_nettype wire

[rtl/planar_trilateration_unit.sv]
// Top level of the planar trilateration unit.
//
// Usage: program baseline_x, third_anchor_x and third_anchor_y over cfg_bus
// (index 0, 1, 2; other indexes are ignored) while no transaction is in
// flight. Each in_stream transaction carries three ranges and yields exactly
// one out_stream transaction with pos_x, pos_y and status, in order.
// The pipeline has four arithmetic stages (squares, numerators, products,
// magnitudes), one restoring-divider stage per quotient bit for both lanes
// at once, and the output register.
// Throughput is one transaction per cycle; the pipeline takes a new range
// triple every cycle in which the output register is empty or being taken.
// When the receiver stalls, the whole pipeline holds; nothing is dropped or
// repeated and in_stream.ready drops until the output moves again.
// Synchronous reset clears all valid bits and the calibration registers,
// so the block reports "not calibrated" until baseline and anchor y are set.
// Negative ranges give status 1 and a zero position; an uncalibrated anchor
// set gives status 2 and a zero position. pos_y saturates to 32 bits.
`default_nettype none
module planar_trilateration_unit (
  input  logic clk,
  input  logic rst_n,
  ptu_in_if.sink    in_stream,
  ptu_out_if.source out_stream,
  ptu_cfg_if.sink   cfg_bus
);
  import ptu_pkg::*;

  // Saturate a sign-magnitude quotient to the 32-bit output range.
  function automatic logic [POS_W-1:0] sat_pos(input logic neg, input logic [Q_W-1:0] q);
    logic [Q_W:0] v;
    logic [Q_W-POS_W+1:0] top;
    v = neg ? ((Q_W+1)'(0) - {1'b0, q}) : {1'b0, q};
    top = v[Q_W:POS_W-1];
    if ((&top) || !(|top)) begin
      return v[POS_W-1:0];
    end
    return v[Q_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  logic adv;
  logic out_valid_r;

  // Configuration registers.
  logic [BASE_W-1:0] base_r;
  logic signed [TX_W-1:0] tx_r;
  logic [TY_W-1:0] ty_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      tx_r <= '0;
      ty_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_BASELINE_X: base_r <= cfg_bus.data[BASE_W-1:0];
        CFG_THIRD_X:    tx_r <= $signed(cfg_bus.data[TX_W-1:0]);
        CFG_THIRD_Y:    ty_r <= cfg_bus.data[TY_W-1:0];
        default: ;
      endcase
    end
  end

  // Terms that depend only on the anchors, refreshed every cycle.
  logic [2*BASE_W-1:0] dd_r;
  logic [2*BASE_W:0] ij_r;
  logic [DX_W-1:0] dvx_r;
  logic [DY_W-1:0] dvy_r;
  logic signed [2*TX_W-1:0] sqi;
  logic [2*TY_W-1:0] sqj;
  logic [BASE_W+TY_W-1:0] dj;

  always_comb begin
    sqi = tx_r * tx_r;
    sqj = ty_r * ty_r;
    dj = base_r * ty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd_r <= '0;
      ij_r <= '0;
      dvx_r <= '0;
      dvy_r <= '0;
    end else begin
      dd_r <= base_r * base_r;
      ij_r <= (2*BASE_W+1)'(sqi[2*TX_W-2:0]) + (2*BASE_W+1)'(sqj);
      dvx_r <= {base_r, 1'b0};
      dvy_r <= {dj, 1'b0};
    end
  end

  // Stall control: everything moves when the output register can move.
  assign adv = !out_valid_r || out_stream.ready;
  assign in_stream.ready = adv;

  // Stage 1: classify and square the ranges.
  logic v1_r;
  status_t st1_r, st1_nxt;
  logic [SQ_W-1:0] sqa_r, sqb_r, sqc_r;

  always_comb begin
    if (in_stream.range_a[DIST_BITS-1] || in_stream.range_b[DIST_BITS-1] ||
        in_stream.range_c[DIST_BITS-1]) begin
      st1_nxt = STAT_NEG;
    end else if (base_r == '0 || ty_r == '0) begin
      st1_nxt = STAT_UNCAL;
    end else begin
      st1_nxt = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_r <= st1_nxt;
      sqa_r <= in_stream.range_a[MAG_W-1:0] * in_stream.range_a[MAG_W-1:0];
      sqb_r <= in_stream.range_b[MAG_W-1:0] * in_stream.range_b[MAG_W-1:0];
      sqc_r <= in_stream.range_c[MAG_W-1:0] * in_stream.range_c[MAG_W-1:0];
    end
  end

  // Stage 2: the two numerators.
  logic v2_r;
  status_t st2_r;
  logic signed [N_W-1:0] n2_r, n3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st2_r <= st1_r;
      n2_r <= $signed(N_W'(sqa_r)) - $signed(N_W'(sqb_r)) + $signed(N_W'(dd_r));
      n3_r <= $signed(N_W'(sqa_r)) - $signed(N_W'(sqc_r)) + $signed(N_W'(ij_r));
    end
  end

  // Stage 3: products for the y numerator.
  logic v3_r;
  status_t st3_r;
  logic signed [NUM_W-1:0] p1_r, p2_r;
  logic signed [N_W-1:0] n2b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st3_r <= st2_r;
      p1_r <= n3_r * $signed({1'b0, base_r});
      p2_r <= tx_r * n2_r;
      n2b_r <= n2_r;
    end
  end

  // Stage 4: sign and magnitude of both dividends.
  logic signed [NUM_W-1:0] num;
  div_lane_t s4_nxt, s4_r, dq;

  always_comb begin
    num = p1_r - p2_r;
    s4_nxt.valid = v3_r;
    s4_nxt.status = st3_r;
    s4_nxt.neg_x = n2b_r[N_W-1];
    s4_nxt.neg_y = num[NUM_W-1];
    s4_nxt.q_x = n2b_r[N_W-1] ? Q_W'($unsigned(-n2b_r)) : Q_W'($unsigned(n2b_r));
    s4_nxt.q_y = num[NUM_W-1] ? Q_W'($unsigned(-num)) : Q_W'($unsigned(num));
    if (st3_r != STAT_OK) begin
      s4_nxt.neg_x = 1'b0;
      s4_nxt.neg_y = 1'b0;
      s4_nxt.q_x = '0;
      s4_nxt.q_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else if (adv) begin
      s4_r <= s4_nxt;
    end
  end

  ptu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .div_x (dvx_r),
    .div_y (dvy_r),
    .din   (s4_r),
    .dout  (dq)
  );

  // Output register with sign restore and saturation.
  logic [POS_W-1:0] pos_x_r, pos_y_r;
  logic [1:0] status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dq.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= dq.status;
      if (dq.status == STAT_OK) begin
        pos_x_r <= sat_pos(dq.neg_x, dq.q_x);
        pos_y_r <= sat_pos(dq.neg_y, dq.q_y);
      end else begin
        pos_x_r <= '0;
        pos_y_r <= '0;
      end
    end
  end

  assign out_stream.valid = out_valid_r;
  assign out_stream.pos_x = $signed(pos_x_r);
  assign out_stream.pos_y = $signed(pos_y_r);
  assign out_stream.status = status_r;
endmodule
`default_nettype wire

[rtl/ptu_checker.sv]
// Port-level assertions for the planar trilateration unit, bound to the top.
`default_nettype none
module ptu_checker (
  input logic clk,
  input logic rst_n,
  ptu_in_if.sink     in_mon,
  ptu_out_if.source  out_mon
);
  import ptu_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_mon.valid && !out_mon.ready |=>
      out_mon.valid && $stable(out_mon.pos_x) && $stable(out_mon.pos_y) &&
      $stable(out_mon.status))
    else $error("result changed while stalled");

  // A rejected item always reports the origin.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_mon.valid && out_mon.status != STAT_OK |->
      out_mon.pos_x == '0 && out_mon.pos_y == '0)
    else $error("rejected result carries a position");

  // The input side is open whenever the output register is empty.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_mon.valid |-> in_mon.ready)
    else $error("input stalled with empty output");

  // Reset flushes the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_mon.valid)
    else $error("result offered right after reset");
endmodule

bind planar_trilateration_unit ptu_checker u_ptu_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_mon  (in_stream),
  .out_mon (out_stream)
);
`default_nettype wire

[dv/ptu_checker.sv]
// Checker that predicts and compares every result of the trilateration unit.
`timescale 1ns / 1ps
module ptu_scoreboard
  import ptu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ptu_in_if.monitor  in_mon,
  ptu_out_if.monitor out_mon,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int        fail_count,
  output int        pending
);
  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    status_t                 status;
  } position_t;

  // Calibration as seen by the block.
  logic [BASE_W-1:0]        anchor_b_x;
  logic signed [TX_W-1:0]   anchor_c_x;
  logic [TY_W-1:0]          anchor_c_y;
  position_t                expected_positions[$];

  assign pending = expected_positions.size();

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Solves the tag position from three ranges under the current calibration.
  function automatic position_t solve_position(logic signed [DIST_BITS-1:0] ra,
                                               logic signed [DIST_BITS-1:0] rb,
                                               logic signed [DIST_BITS-1:0] rc);
    position_t p;
    longint a, b, c, d, i, j, n2, n3, num;
    p.pos_x = '0;
    p.pos_y = '0;
    p.status = STAT_OK;
    a = longint'(ra);
    b = longint'(rb);
    c = longint'(rc);
    d = longint'(anchor_b_x);
    i = longint'(anchor_c_x);
    j = longint'(anchor_c_y);
    if (a < 0 || b < 0 || c < 0) begin
      p.status = STAT_NEG;
    end else if (d == 0 || j == 0) begin
      p.status = STAT_UNCAL;
    end else begin
      n2 = a * a - b * b + d * d;
      n3 = a * a - c * c + i * i + j * j;
      num = n3 * d - i * n2;
      // SystemVerilog division truncates toward zero.
      p.pos_x = POS_W'(clamp32(n2 / (2 * d)));
      p.pos_y = POS_W'(clamp32(num / (2 * d * j)));
    end
    return p;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    position_t exp_pos;
    if (!rst_n) begin
      anchor_b_x <= '0;
      anchor_c_x <= '0;
      anchor_c_y <= '0;
      fail_count <= 0;
      expected_positions.delete();
    end else begin
      // A calibration transaction updates the predicted registers.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASELINE_X: anchor_b_x <= cfg_data[BASE_W-1:0];
          CFG_THIRD_X: anchor_c_x <= cfg_data[TX_W-1:0];
          CFG_THIRD_Y: anchor_c_y <= cfg_data[TY_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_positions.push_back(solve_position(in_mon.range_a, in_mon.range_b,
                                                    in_mon.range_c));
      // Each result transaction is matched against the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_positions.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_pos = expected_positions.pop_front();
          if (out_mon.status !== exp_pos.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_mon.status,
                                      exp_pos.status));
          if (out_mon.pos_x !== exp_pos.pos_x)
            report_mismatch($sformatf("pos_x %0d, expected %0d", out_mon.pos_x,
                                      exp_pos.pos_x));
          if (out_mon.pos_y !== exp_pos.pos_y)
            report_mismatch($sformatf("pos_y %0d, expected %0d", out_mon.pos_y,
                                      exp_pos.pos_y));
        end
      end
    end
  end
endmodule

[dv/tb_planar_trilateration_unit.sv]
// Testbench top: stimulus, calibration phases and verdict for the unit.
`timescale 1ns / 1ps
module tb_planar_trilateration_unit;
  import ptu_pkg::*;

  localparam int LATENCY = Q_W + 5;
  // An index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic idle_enable = 1'b1;
  logic hold_off = 1'b0;
  int   fail_count;
  int   pending;

  ptu_in_if  in_ch ();
  ptu_out_if out_ch ();
  ptu_cfg_if cfg_ch ();

  planar_trilateration_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_stream(in_ch.sink),
    .out_stream(out_ch.source),
    .cfg_bus(cfg_ch.sink)
  );

  ptu_scoreboard checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_mon(in_ch.monitor),
    .out_mon(out_ch.monitor),
    .cfg_valid(cfg_ch.valid),
    .cfg_ready(cfg_ch.ready),
    .cfg_index(cfg_ch.index),
    .cfg_data(cfg_ch.data),
    .fail_count(fail_count),
    .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.range_a = '0;
    in_ch.range_b = '0;
    in_ch.range_c = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int burst;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic calibrate(int bx, int cx, int cy);
    write_reg(CFG_BASELINE_X, CFG_DATA_W'(bx));
    write_reg(CFG_THIRD_X, CFG_DATA_W'(cx));
    write_reg(CFG_THIRD_Y, CFG_DATA_W'(cy));
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
  endtask

  // Sends one range triple, with an optional idle burst first.
  task automatic send_ranges(int ra, int rb, int rc);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.range_a <= DIST_BITS'(ra);
    in_ch.range_b <= DIST_BITS'(rb);
    in_ch.range_c <= DIST_BITS'(rc);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic int pick_range();
    case ($urandom_range(0, 9))
      0: return -int'($urandom_range(1, 32768));
      1: return 32767;
      2: return 0;
      3: return $urandom_range(0, 255);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++)
      send_ranges(pick_range(), pick_range(), pick_range());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Uncalibrated after reset, and negative ranges take precedence.
    send_ranges(100, 50, 60);
    send_ranges(-1, 50, 60);
    drain();

    calibrate(32767, -32767, 32767);
    send_ranges(0, 0, 0);
    send_ranges(32767, 32767, 32767);
    send_ranges(32767, 0, 0);
    send_ranges(0, 32767, 0);
    send_ranges(0, 0, 32767);
    send_ranges(-32768, 0, 0);
    send_ranges(0, -32768, 0);
    send_ranges(0, 0, -1);
    drain();

    // Tiny anchor triangle gives the largest y, which saturates.
    calibrate(1, 32767, 1);
    send_ranges(32767, 0, 0);
    send_ranges(0, 32767, 32767);
    send_ranges(32767, 32767, 0);
    send_ranges(5, 3, 4);
    drain();
    calibrate(1, -32767, 1);
    send_ranges(32767, 0, 0);
    send_ranges(0, 32767, 32767);
    drain();

    // Baseline set but anchor y zero is still uncalibrated.
    calibrate(1000, 500, 0);
    send_ranges(600, 700, 800);
    drain();

    calibrate(4000, 2000, 3000);
    random_phase(300);
    // Long receiver stall while items keep coming.
    hold_off = 1'b1;
    random_phase(150);
    drain();

    calibrate($urandom_range(1, 32767), int'($urandom_range(0, 65534)) - 32767,
              $urandom_range(1, 32767));
    random_phase(300);
    drain();

    calibrate($urandom_range(1, 100), int'($urandom_range(0, 65534)) - 32767,
              $urandom_range(1, 100));
    random_phase(250);
    drain();

    // Final part runs without idle cycles on either side.
    idle_enable = 1'b0;
    calibrate(32767, 32767, 32767);
    random_phase(200);
    drain();

    if (fail_count == 0) begin
      $display("[planar_trilateration_unit] OK");
    end else begin
      $display("[planar_trilateration_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[planar_trilateration_unit] ERROR");
    $finish;
  end
endmodule
